>>> rtl/core/tlv_stream_deframer_defines.svh
// Assertion macros shared by the deframer RTL files.
`ifndef TLV_STREAM_DEFRAMER_DEFINES_SVH
`define TLV_STREAM_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TLVD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TLVD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tlvd_pkg.sv
// Types and constants shared by the deframer modules.
package tlvd_pkg;

    // Depth of the result queue in front of the output channel.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Configuration register indexes.
    localparam logic [1:0] REG_FORMAT     = 2'd0;
    localparam logic [1:0] REG_FILTER_EN  = 2'd1;
    localparam logic [1:0] REG_FILTER_TAG = 2'd2;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_HEADER   = 3'd0,
        KIND_VALUE    = 3'd1,
        KIND_DONE     = 3'd2,
        KIND_NOTFOUND = 3'd3,
        KIND_TRUNC    = 3'd4,
        KIND_OVERRUN  = 3'd5
    } kind_t;

    // Parse phase, one-hot.
    typedef enum logic [1:0] {
        PH_HEADER = 2'b01,
        PH_VALUE  = 2'b10
    } phase_t;

    // One result item.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] tag;
        logic [15:0] length;
        logic [7:0]  value_byte;
        logic [15:0] value_offset;
        logic        last;
    } result_t;

    // Which of the two result slots of one byte are filled.
    typedef struct packed {
        logic v0;
        logic v1;
    } push_t;

endpackage

>>> rtl/core/tlv_stream_deframer.sv
// Top level of the streaming tag-length-value deframer.
//
// Bytes of a message enter on the s_ channel: s_tdata carries the byte, s_tuser
// marks the first byte of a message and s_tlast the final one. Results leave on
// the m_ channel: m_tuser gives the kind, m_tdata the tag, length, value byte and
// offset, and m_tlast ends an element's value or a message's status request.
// The cfg_ port writes the format, filter enable and filter tag registers.
// The user must use it only while the block is idle; the block does not enforce it.
// An accepted byte is held in the input register, passes the parser, and its
// results are written into the result queue that drives the m_ channel. The
// block takes one byte per cycle while the queue has two entries free; a
// message-end byte that also ends a header or value of a matching tag gives two
// results, which are written into the queue together.
// Throughput is set by the result queue, which drains one request per cycle while m_tready is high.
// Reset clears the registers to their defaults, the parse state and the queue.
// When the receiver stalls, results wait in the queue of QUEUE_DEPTH entries and
// s_tready falls once fewer than two entries are free and the input register is
// full; no request is lost.
module tlv_stream_deframer
    import tlvd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] first_of_message
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [15:0] tag, [31:16] length, [39:32] value_byte,
                                   // [55:40] value_offset
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       in_last_reg;
    logic       room2;
    logic       consume;
    push_t      push;
    push_t      push_q;
    result_t    res0;
    result_t    res1;
    result_t    out_res;

    // The input register is emptied into the parser when the queue has room.
    assign consume  = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (consume)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
            in_last_reg  <= s_tlast;
        end
    end

    tlvd_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .consume          (consume),
        .data_byte        (in_byte_reg),
        .first_of_message (in_first_reg),
        .last_of_message  (in_last_reg),
        .push             (push),
        .res0             (res0),
        .res1             (res1)
    );

    tlvd_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_q),
        .res0      (res0),
        .res1      (res1),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Results are pushed only on the cycle the parser takes the byte.
    always_comb
    begin
        push_q.v0 = push.v0 && consume;
        push_q.v1 = push.v1 && consume;
    end

    assign m_tdata = {out_res.value_offset, out_res.value_byte, out_res.length, out_res.tag};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

>>> rtl/core/tlvd_parser.sv
// Header and value parser: configuration registers, parse state and result build.
`include "tlv_stream_deframer_defines.svh"

module tlvd_parser
    import tlvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        consume,
    input  logic [7:0]  data_byte,
    input  logic        first_of_message,
    input  logic        last_of_message,
    output push_t       push,
    output result_t     res0,
    output result_t     res1
);

    logic        fmt_reg;
    logic        fen_reg;
    logic [15:0] ftag_reg;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hc_reg, hc_next;
    logic [15:0] tag_reg, tag_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] vc_reg, vc_next;
    logic        seen_reg, seen_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= 1'b0;
            fen_reg  <= 1'b0;
            ftag_reg <= 16'h0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FORMAT:     fmt_reg  <= cfg_data[0];
                REG_FILTER_EN:  fen_reg  <= cfg_data[0];
                REG_FILTER_TAG: ftag_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Per-byte parse: header assembly, value counting and status at message end.
    always_comb
    begin
        phase_t      ph_c;
        logic [1:0]  hc_c;
        logic [15:0] tag_c;
        logic [15:0] len_c;
        logic [15:0] vc_c;
        logic        seen_c;
        logic [1:0]  hc_inc;
        logic        complete;
        logic        match;
        logic        elem_end;
        kind_t       status;

        ph_c   = first_of_message ? PH_HEADER : phase_reg;
        hc_c   = first_of_message ? 2'd0 : hc_reg;
        tag_c  = first_of_message ? 16'h0000 : tag_reg;
        len_c  = first_of_message ? 16'h0000 : len_reg;
        vc_c   = first_of_message ? 16'h0000 : vc_reg;
        seen_c = first_of_message ? 1'b0 : seen_reg;

        phase_next = ph_c;
        hc_next    = hc_c;
        tag_next   = tag_c;
        len_next   = len_c;
        vc_next    = vc_c;
        seen_next  = seen_c;
        hc_inc     = hc_c + 2'd1;
        complete   = 1'b0;
        match      = 1'b0;
        elem_end   = 1'b0;
        status     = KIND_DONE;

        push.v0 = 1'b0;
        push.v1 = 1'b0;
        res0.kind         = KIND_HEADER;
        res0.tag          = 16'h0000;
        res0.length       = 16'h0000;
        res0.value_byte   = 8'h00;
        res0.value_offset = 16'h0000;
        res0.last         = 1'b0;
        res1 = res0;

        if (ph_c == PH_HEADER)
        begin
            if (!fmt_reg)
            begin
                if (hc_c == 2'd0)
                begin
                    tag_next = {8'h00, data_byte};
                    len_next = 16'h0000;
                end
                else
                begin
                    len_next = {8'h00, data_byte};
                end
            end
            else
            begin
                case (hc_c)
                    2'd0:
                    begin
                        tag_next = {data_byte, 8'h00};
                        len_next = 16'h0000;
                    end
                    2'd1: tag_next = {tag_c[15:8], data_byte};
                    2'd2: len_next = {data_byte, 8'h00};
                    default: len_next = {len_c[15:8], data_byte};
                endcase
            end
            complete = fmt_reg ? (hc_inc == 2'd0) : (hc_inc >= 2'd2 || hc_inc == 2'd0);
            hc_next  = complete ? 2'd0 : hc_inc;
            if (complete)
            begin
                match = !fen_reg || (tag_next == ftag_reg);
                if (match)
                begin
                    seen_next = seen_c | fen_reg;
                    push.v0   = 1'b1;
                    res0.kind   = KIND_HEADER;
                    res0.tag    = tag_next;
                    res0.length = len_next;
                end
                if (len_next != 16'h0000)
                begin
                    phase_next = PH_VALUE;
                    vc_next    = 16'h0000;
                end
            end
        end
        else
        begin
            match    = !fen_reg || (tag_c == ftag_reg);
            elem_end = ({1'b0, vc_c} + 17'd1) >= {1'b0, len_c};
            if (match)
            begin
                push.v0 = 1'b1;
                res0.kind         = KIND_VALUE;
                res0.tag          = tag_c;
                res0.length       = len_c;
                res0.value_byte   = data_byte;
                res0.value_offset = vc_c;
                res0.last         = elem_end;
            end
            vc_next = vc_c + 16'd1;
            if (elem_end)
            begin
                phase_next = PH_HEADER;
                vc_next    = 16'h0000;
            end
        end

        // Status at message end; errors take precedence over tag not found.
        if (last_of_message)
        begin
            if (phase_next != PH_HEADER)
                status = KIND_OVERRUN;
            else if (hc_next != 2'd0)
                status = KIND_TRUNC;
            else if (fen_reg && !seen_next)
                status = KIND_NOTFOUND;
            else
                status = KIND_DONE;
            push.v1     = 1'b1;
            res1.kind   = status;
            res1.tag    = tag_next;
            res1.length = len_next;
            res1.last   = 1'b1;

            phase_next = PH_HEADER;
            hc_next    = 2'd0;
            tag_next   = 16'h0000;
            len_next   = 16'h0000;
            vc_next    = 16'h0000;
            seen_next  = 1'b0;
        end
    end

    // Parse state, advanced once per consumed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hc_reg    <= 2'd0;
            tag_reg   <= 16'h0000;
            len_reg   <= 16'h0000;
            vc_reg    <= 16'h0000;
            seen_reg  <= 1'b0;
        end
        else if (consume)
        begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            vc_reg    <= vc_next;
            seen_reg  <= seen_next;
        end
    end

    // A value phase is only entered from a finished header with a non-zero length.
    `TLVD_ASSERT_NOW(a_value_no_header, phase_reg == PH_VALUE, hc_reg == 2'd0, "value phase with partial header")
    `TLVD_ASSERT_NOW(a_value_len, phase_reg == PH_VALUE, len_reg != 16'h0000, "value phase with zero length")
    // The message end returns the parser to a clean header phase.
    `TLVD_ASSERT_NEXT(a_end_clears, consume && last_of_message, phase_reg == PH_HEADER && hc_reg == 2'd0 && !seen_reg, "state not cleared at message end")

endmodule

>>> rtl/core/tlvd_out_queue.sv
// Result queue that takes up to two results a cycle and feeds the output channel.
`include "tlv_stream_deframer_defines.svh"

module tlvd_out_queue
    import tlvd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  result_t res0,
    input  result_t res1,
    output logic    room2,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [1:0]       push_n;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Occupancy and pointer bookkeeping.
    always_comb
    begin
        push_n      = {1'b0, push.v0} + {1'b0, push.v1};
        pop         = out_valid && out_ready;
        wr_ptr_inc  = ptr_inc(wr_ptr_reg);
        wr_ptr_next = (push_n == 2'd2) ? ptr_inc(wr_ptr_inc)
                    : (push_n == 2'd1) ? wr_ptr_inc : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    assign room2     = count_reg <= CNT_W'(DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_res   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; a lone status result takes the first free slot.
    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= res0;
            if (push.v1)
                mem_reg[wr_ptr_inc] <= res1;
        end
        else if (push.v1)
        begin
            mem_reg[wr_ptr_reg] <= res1;
        end
    end

    // Requests are only pushed while two entries are free.
    `TLVD_ASSERT_NOW(a_no_overflow, push.v0 || push.v1, room2, "result queue overflow")
    `TLVD_ASSERT_NEXT(a_count_track, 1'b1, count_reg == $past(count_reg) + CNT_W'($past(push_n)) - CNT_W'($past(pop)), "queue count out of step")

endmodule
